// File: rtl/wfba_pkg.sv
// shared types and constants for the worst-fit partition allocator
// no dependencies; imported by wfba_cell and worst_fit_block_allocator_core
`timescale 1ns / 1ps

package wfba_pkg;

   localparam int SIZE_W  = 16;  // request / load size field
   localparam int BLOCK_W = 5;   // load_index and chosen_block fields
   localparam int COUNT_W = 6;   // block_count register
   localparam int ADDR_W  = 3;
   localparam int DATA_W  = 32;

   // request word function codes
   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_ALLOC = 1'b1;

   // register index (paddr bit 2)
   localparam logic CSR_BLOCK_COUNT = 1'b0;

   typedef struct packed {
      logic               func;
      logic [BLOCK_W-1:0] load_index;
      logic [SIZE_W-1:0]  size;
   } wfba_req_type;

   typedef struct packed {
      logic               granted;
      logic [BLOCK_W-1:0] chosen_block;
      logic [SIZE_W-1:0]  fragment;
   } wfba_rsp_type;

   // scan token flags handed from cell to cell
   typedef struct packed {
      logic valid;
      logic found;
   } wfba_tok_type;

   // strobes broadcast to every cell
   typedef struct packed {
      logic load_en;
      logic mark_en;
   } wfba_bcast_type;

endpackage

// File: rtl/worst_fit_block_allocator_core.sv
// Worst-fit partition allocator. A row of MAX_BLOCKS cells holds one partition
// each (size and used flag). A load word writes a partition in the cycle it is
// accepted and gives no result. An allocation word launches a scan token that
// moves one cell per cycle, keeping the largest free fitting partition seen so
// far (lowest index on ties); its result is registered as the token leaves the
// last cell, and the chosen partition is marked used at that same edge.
// One allocation is in the row at a time; a new word is taken once the scan is
// done and the result register is empty or being read.
// block_count sets how many partitions take part, from index zero.
// Depends on wfba_pkg and wfba_cell.
`timescale 1ns / 1ps

module worst_fit_block_allocator_core import wfba_pkg::*; #(
   parameter int MAX_BLOCKS = 32,
   parameter int SIZE_BITS  = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  wfba_req_type        req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output wfba_rsp_type        rsp_data,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [ADDR_W-1:0]   paddr,
   input  logic [DATA_W-1:0]   pwdata,
   output logic [DATA_W-1:0]   prdata,
   output logic                pready
);

   localparam int IDX_W = $clog2(MAX_BLOCKS);
   localparam int CMP_W = (SIZE_BITS > SIZE_W) ? SIZE_BITS : SIZE_W;

   logic [COUNT_W-1:0] block_count_ff;
   logic               busy_ff, busy_in;
   logic               rsp_valid_ff, rsp_valid_in;
   wfba_rsp_type       rsp_data_ff, rsp_data_in;

   logic               req_acc, csr_wr, csr_sel;
   wfba_bcast_type     bcast;

   wfba_tok_type         tok       [0:MAX_BLOCKS];
   logic [IDX_W-1:0]     tok_idx   [0:MAX_BLOCKS];
   logic [SIZE_BITS-1:0] tok_size  [0:MAX_BLOCKS];
   logic [SIZE_W-1:0]    tok_req   [0:MAX_BLOCKS];
   logic [MAX_BLOCKS:0]  tok_valid_vec;

   // configuration port
   assign pready  = 1'b1;
   assign csr_sel = paddr[2] == CSR_BLOCK_COUNT;
   assign csr_wr  = psel && penable && pwrite && pready && csr_sel;
   assign prdata  = csr_sel ? DATA_W'(block_count_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_count_ff <= '0;
      end else if (csr_wr) begin
         block_count_ff <= pwdata[COUNT_W-1:0];
      end
   end

   // input side
   assign req_ready = !busy_ff && (!rsp_valid_ff || rsp_ready);
   assign req_acc   = req_valid && req_ready;

   assign tok[0].valid = req_acc && (req_data.func == FUNC_ALLOC);
   assign tok[0].found = 1'b0;
   assign tok_idx[0]   = '0;
   assign tok_size[0]  = '0;
   assign tok_req[0]   = req_data.size;

   assign bcast.load_en = req_acc && (req_data.func == FUNC_LOAD);
   assign bcast.mark_en = tok[MAX_BLOCKS].valid && tok[MAX_BLOCKS].found;

   for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
      wfba_cell #(
         .IDX       (i),
         .SIZE_BITS (SIZE_BITS),
         .IDX_W     (IDX_W)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .bcast         (bcast),
         .load_index    (req_data.load_index),
         .load_size     (req_data.size),
         .mark_idx      (tok_idx[MAX_BLOCKS]),
         .block_count   (block_count_ff),
         .tok_in        (tok[i]),
         .best_idx_in   (tok_idx[i]),
         .best_size_in  (tok_size[i]),
         .req_size_in   (tok_req[i]),
         .tok_out       (tok[i+1]),
         .best_idx_out  (tok_idx[i+1]),
         .best_size_out (tok_size[i+1]),
         .req_size_out  (tok_req[i+1])
      );
   end

   for (genvar k = 0; k <= MAX_BLOCKS; k++) begin : g_vld
      assign tok_valid_vec[k] = tok[k].valid;
   end

   // scan control and result register
   always_comb begin
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (tok[0].valid) begin
         busy_in = 1'b1;
      end else if (tok[MAX_BLOCKS].valid) begin
         busy_in = 1'b0;
      end
      if (tok[MAX_BLOCKS].valid) begin
         rsp_valid_in = 1'b1;
         if (tok[MAX_BLOCKS].found) begin
            rsp_data_in.granted      = 1'b1;
            rsp_data_in.chosen_block = BLOCK_W'(tok_idx[MAX_BLOCKS]);
            rsp_data_in.fragment     = SIZE_W'(CMP_W'(tok_size[MAX_BLOCKS])
                                              - CMP_W'(tok_req[MAX_BLOCKS]));
         end else begin
            rsp_data_in = '0;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // at most one scan token anywhere in the row
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $countones(tok_valid_vec) <= 1)
      else $error("more than one scan token in the cell row");

   // a token leaving the row belongs to a scan in progress
   a_tail_busy: assert property (@(posedge clock) disable iff (reset)
      tok[MAX_BLOCKS].valid |-> busy_ff)
      else $error("scan token leaves the row while idle");

   // a finishing scan never lands on an undelivered result
   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      tok[MAX_BLOCKS].valid |-> !rsp_valid_ff)
      else $error("scan result overwrites a pending word");

   // an accepted allocation keeps the block busy next cycle
   a_alloc_busy: assert property (@(posedge clock) disable iff (reset)
      tok[0].valid |=> busy_ff)
      else $error("allocation accepted without starting a scan");

endmodule

// File: rtl/wfba_cell.sv
// one partition cell: stored size, used flag and one stage of the scan token
// depends on wfba_pkg
`timescale 1ns / 1ps

module wfba_cell import wfba_pkg::*; #(
   parameter int IDX       = 0,
   parameter int SIZE_BITS = 16,
   parameter int IDX_W     = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  wfba_bcast_type       bcast,
   input  logic [BLOCK_W-1:0]   load_index,
   input  logic [SIZE_W-1:0]    load_size,
   input  logic [IDX_W-1:0]     mark_idx,
   input  logic [COUNT_W-1:0]   block_count,
   input  wfba_tok_type         tok_in,
   input  logic [IDX_W-1:0]     best_idx_in,
   input  logic [SIZE_BITS-1:0] best_size_in,
   input  logic [SIZE_W-1:0]    req_size_in,
   output wfba_tok_type         tok_out,
   output logic [IDX_W-1:0]     best_idx_out,
   output logic [SIZE_BITS-1:0] best_size_out,
   output logic [SIZE_W-1:0]    req_size_out
);

   localparam int CMP_W = (SIZE_BITS > SIZE_W) ? SIZE_BITS : SIZE_W;

   logic [SIZE_BITS-1:0] part_size_ff;
   logic                 part_used_ff;
   wfba_tok_type         tok_ff, tok_in_next;
   logic [IDX_W-1:0]     best_idx_ff, best_idx_in_next;
   logic [SIZE_BITS-1:0] best_size_ff, best_size_in_next;
   logic [SIZE_W-1:0]    req_size_ff;

   logic active, fits, better, take, load_hit, mark_hit;

   assign active   = 32'(block_count) > 32'(IDX);
   assign fits     = !part_used_ff && (CMP_W'(part_size_ff) >= CMP_W'(req_size_in));
   // strict compare keeps the earlier cell on a tie
   assign better   = !tok_in.found || (part_size_ff > best_size_in);
   assign take     = tok_in.valid && active && fits && better;
   assign load_hit = bcast.load_en && (32'(load_index) == 32'(IDX));
   assign mark_hit = bcast.mark_en && (mark_idx == IDX_W'(IDX));

   always_comb begin
      tok_in_next       = tok_in;
      best_idx_in_next  = best_idx_in;
      best_size_in_next = best_size_in;
      if (take) begin
         tok_in_next.found = 1'b1;
         best_idx_in_next  = IDX_W'(IDX);
         best_size_in_next = part_size_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         part_used_ff <= 1'b0;
         tok_ff       <= '0;
      end else begin
         tok_ff <= tok_in_next;
         if (load_hit) begin
            part_used_ff <= 1'b0;
         end else if (mark_hit) begin
            part_used_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_hit) begin
         part_size_ff <= SIZE_BITS'(load_size);
      end
      best_idx_ff  <= best_idx_in_next;
      best_size_ff <= best_size_in_next;
      req_size_ff  <= req_size_in;
   end

   assign tok_out       = tok_ff;
   assign best_idx_out  = best_idx_ff;
   assign best_size_out = best_size_ff;
   assign req_size_out  = req_size_ff;

endmodule

// File: tb/tb_worst_fit_block_allocator_core.sv
// testbench for worst_fit_block_allocator_core: directed table then random words,
// typed directed rows checked against their listed grant, other results against a
// behavioral copy of the partition table; depends on wfba_pkg and the core rtl
`timescale 1ns / 1ps

module tb_worst_fit_block_allocator_core;
   import wfba_pkg::*;

   localparam int NUM_PARTS       = 32;
   localparam int SCAN_LATENCY    = NUM_PARTS + 1;
   localparam int SETTLE_CYCLES   = SCAN_LATENCY + 7;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int RANDOM_CHUNKS   = 14;
   localparam int CHUNK_WORDS     = 100;
   localparam int MAX_PRINTS      = 60;

   localparam logic [ADDR_W-1:0] ADDR_BLOCK_COUNT = {CSR_BLOCK_COUNT, 2'b00};
   localparam logic [ADDR_W-1:0] ADDR_SPARE       = {1'b1, 2'b00};

   typedef struct {
      int           count;
      wfba_req_type word;
      bit           typed;
      wfba_rsp_type grant;
   } stim_row_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   wfba_req_type      req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   wfba_rsp_type      rsp_data;
   logic              psel      = 1'b0;
   logic              penable   = 1'b0;
   logic              pwrite    = 1'b0;
   logic [ADDR_W-1:0] paddr     = '0;
   logic [DATA_W-1:0] pwdata    = '0;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   // shadow partition table
   logic [SIZE_W-1:0]  part_size [NUM_PARTS];
   bit                 part_used [NUM_PARTS];
   logic [COUNT_W-1:0] cur_count;

   wfba_rsp_type pending_grants [$];
   stim_row_type directed_rows [$];
   int           error_count   = 0;
   int           send_idle_pct = 0;
   int           rsp_idle_pct  = 0;
   int           idle_cycles   = 0;
   logic         hold_trig     = 1'b0;
   logic         hold_seen;
   int           hold_left;

   worst_fit_block_allocator_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (error_count < MAX_PRINTS) begin
         $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
      end
      error_count++;
   endtask

   // applies one accepted word to the shadow table; allocations give a grant word
   task automatic allocate_or_load(input wfba_req_type w, output bit has_grant,
                                   output wfba_rsp_type g);
      int  lim;
      int  best;
      bit  found;
      best      = 0;
      found     = 1'b0;
      has_grant = 1'b0;
      g         = '0;
      if (w.func == FUNC_LOAD) begin
         part_size[w.load_index] = w.size;
         part_used[w.load_index] = 1'b0;
      end else begin
         lim = (int'(cur_count) > NUM_PARTS) ? NUM_PARTS : int'(cur_count);
         for (int j = 0; j < lim; j++) begin
            if (!part_used[j] && part_size[j] >= w.size) begin
               if (!found || part_size[j] > part_size[best]) begin
                  best  = j;
                  found = 1'b1;
               end
            end
         end
         has_grant = 1'b1;
         if (found) begin
            part_used[best] = 1'b1;
            g.granted       = 1'b1;
            g.chosen_block  = best[BLOCK_W-1:0];
            g.fragment      = part_size[best] - w.size;
         end
      end
   endtask

   task automatic send_word(input wfba_req_type w, input bit typed, input wfba_rsp_type want);
      bit           has_grant;
      wfba_rsp_type g;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      allocate_or_load(w, has_grant, g);
      if (has_grant) begin
         pending_grants.push_back(typed ? want : g);
      end
   endtask

   // sender pauses until every grant is back and the scan row is empty
   task automatic drain_block();
      req_valid <= 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= addr;
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_block_count(input logic [COUNT_W-1:0] v);
      logic [DATA_W-1:0] rd;
      logic [DATA_W-1:0] wd;
      drain_block();
      wd = $urandom();
      wd[COUNT_W-1:0] = v;
      csr_access(1'b1, ADDR_BLOCK_COUNT, wd, rd);
      cur_count = v;
      csr_access(1'b0, ADDR_BLOCK_COUNT, '0, rd);
      if (rd != DATA_W'(v)) report_mismatch("block_count readback", rd, DATA_W'(v));
   endtask

   task automatic add_row(input int cnt, input logic func, input int idx, input int sz,
                          input bit typed, input int g, input int blk, input int frag);
      stim_row_type r;
      r.count                = cnt;
      r.word.func            = func;
      r.word.load_index      = idx[BLOCK_W-1:0];
      r.word.size            = sz[SIZE_W-1:0];
      r.typed                = typed;
      r.grant.granted        = g[0];
      r.grant.chosen_block   = blk[BLOCK_W-1:0];
      r.grant.fragment       = frag[SIZE_W-1:0];
      directed_rows.push_back(r);
   endtask

   function automatic logic [COUNT_W-1:0] pick_count();
      case ($urandom_range(7))
         0: pick_count = 6'd0;
         1: pick_count = 6'd1;
         2: pick_count = 6'd31;
         3: pick_count = 6'd32;
         4: pick_count = 6'd33;
         5: pick_count = 6'd63;
         default: pick_count = COUNT_W'($urandom_range(63));
      endcase
   endfunction

   function automatic wfba_req_type random_word();
      wfba_req_type w;
      int           r;
      logic [SIZE_W-1:0] ps;
      w.load_index = BLOCK_W'($urandom_range(NUM_PARTS - 1));
      w.size       = SIZE_W'($urandom());
      r            = $urandom_range(99);
      if (r < 45) begin
         w.func = FUNC_LOAD;
         case ($urandom_range(9))
            0: w.size = '0;
            1: w.size = '1;
            2, 3: w.size = SIZE_W'($urandom_range(255));
            default: ;
         endcase
      end else begin
         w.func = FUNC_ALLOC;
         ps     = part_size[$urandom_range(NUM_PARTS - 1)];
         r      = $urandom_range(99);
         if (r < 15) w.size = '0;
         else if (r < 25) w.size = '1;
         else if (r < 60) w.size = ps;
         else if (r < 80) w.size = (ps > 3) ? ps - SIZE_W'($urandom_range(3)) : '0;
         else if (r < 90) w.size = SIZE_W'($urandom_range(255));
      end
      return w;
   endfunction

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_seen <= 1'b0;
         hold_left <= 0;
      end else if (hold_trig != hold_seen) begin
         hold_seen <= hold_trig;
         hold_left <= RSP_HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      wfba_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_grants.size() == 0) begin
            report_mismatch("unexpected result word", 32'(rsp_data), '0);
         end else begin
            want = pending_grants.pop_front();
            if (rsp_data.granted !== want.granted)
               report_mismatch("granted", 32'(rsp_data.granted), 32'(want.granted));
            if (rsp_data.chosen_block !== want.chosen_block)
               report_mismatch("chosen_block", 32'(rsp_data.chosen_block),
                               32'(want.chosen_block));
            if (rsp_data.fragment !== want.fragment)
               report_mismatch("fragment", 32'(rsp_data.fragment), 32'(want.fragment));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (psel && penable && pready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_worst_fit_block_allocator_core failed");
            $finish;
         end
      end
   end

   initial begin
      logic [DATA_W-1:0] rd;
      for (int j = 0; j < NUM_PARTS; j++) begin
         part_size[j] = '0;
         part_used[j] = 1'b0;
      end
      cur_count = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      csr_access(1'b0, ADDR_BLOCK_COUNT, '0, rd);
      if (rd != '0) report_mismatch("block_count after reset", rd, '0);

      // every partition gets a size before any scan can reach it
      for (int j = 0; j < NUM_PARTS; j++) begin
         send_word({FUNC_LOAD, BLOCK_W'(j), SIZE_W'(16'h0010)}, 1'b0, '0);
      end

      // count, func, index, size, typed, granted, block, fragment
      add_row(0,  FUNC_ALLOC, 7,  'h0000, 1, 0, 0,  0);       // zero count
      add_row(0,  FUNC_ALLOC, 31, 'hFFFF, 1, 0, 0,  0);
      add_row(32, FUNC_LOAD,  0,  'hFFFF, 0, 0, 0,  0);
      add_row(32, FUNC_LOAD,  1,  'hFFFF, 0, 0, 0,  0);
      add_row(32, FUNC_ALLOC, 0,  'hFFFF, 1, 1, 0,  0);       // tie goes low
      add_row(32, FUNC_ALLOC, 0,  'hFFFF, 1, 1, 1,  0);
      add_row(32, FUNC_ALLOC, 0,  'hFFFF, 1, 0, 0,  0);       // nothing fits
      add_row(32, FUNC_LOAD,  0,  'hFFFF, 0, 0, 0,  0);       // load frees a used one
      add_row(32, FUNC_ALLOC, 31, 'h0000, 1, 1, 0,  'hFFFF);
      add_row(32, FUNC_LOAD,  31, 'h8000, 0, 0, 0,  0);
      add_row(32, FUNC_ALLOC, 0,  'h0001, 1, 1, 31, 'h7FFF);
      add_row(32, FUNC_ALLOC, 0,  'h0011, 1, 0, 0,  0);
      add_row(32, FUNC_ALLOC, 0,  'h0010, 1, 1, 2,  0);
      add_row(1,  FUNC_ALLOC, 0,  'h0000, 1, 0, 0,  0);
      add_row(63, FUNC_LOAD,  0,  'h0000, 0, 0, 0,  0);       // count saturates
      add_row(63, FUNC_ALLOC, 0,  'h0000, 0, 0, 0,  0);
      add_row(33, FUNC_ALLOC, 0,  'h0010, 0, 0, 0,  0);
      add_row(2,  FUNC_LOAD,  1,  'h0000, 0, 0, 0,  0);
      add_row(2,  FUNC_ALLOC, 0,  'h0000, 0, 0, 0,  0);
      add_row(2,  FUNC_ALLOC, 0,  'h0000, 0, 0, 0,  0);
      add_row(2,  FUNC_ALLOC, 0,  'h0000, 0, 0, 0,  0);
      add_row(32, FUNC_LOAD,  31, 'hFFFF, 0, 0, 0,  0);
      add_row(32, FUNC_ALLOC, 0,  'h8000, 0, 0, 0,  0);
      add_row(32, FUNC_ALLOC, 0,  'hFFFF, 0, 0, 0,  0);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].count != int'(cur_count)) begin
            set_block_count(COUNT_W'(directed_rows[i].count));
         end
         send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].grant);
      end

      for (int c = 0; c < RANDOM_CHUNKS; c++) begin
         if (c < 5) begin
            send_idle_pct = 22;
            rsp_idle_pct  = 47;
         end else if (c < 10) begin
            send_idle_pct = 47;
            rsp_idle_pct  = 22;
         end else begin
            send_idle_pct = 0;
            rsp_idle_pct  = 0;
         end
         set_block_count((c == 0 || c == 10) ? 6'd32 : pick_count());
         if (c == 3) begin
            // writes to an unmapped register leave the count alone
            csr_access(1'b1, ADDR_SPARE, $urandom(), rd);
         end
         if (c == 10) begin
            hold_trig <= ~hold_trig;
         end
         for (int k = 0; k < CHUNK_WORDS; k++) begin
            if (k == CHUNK_WORDS / 2 && c % 4 == 1) begin
               drain_block();
            end
            send_word(random_word(), 1'b0, '0);
         end
      end

      drain_block();
      if (error_count == 0) begin
         $display("tb_worst_fit_block_allocator_core passed");
      end else begin
         $display("tb_worst_fit_block_allocator_core failed");
      end
      $finish;
   end

endmodule
